/* rtl/core/assert_macros.svh */
// Assertion macros shared by the joystick octant selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked assertion, off while reset is held.
`define JOS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication form: antecedent holds, consequent holds in the same cycle.
`define JOS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/jos_pkg.sv */
// Shared constants and types for the joystick octant selector.
package jos_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int RADIUS_BITS = 12;
    localparam int SECTOR_BITS = 4;

    // Mid-scale sample value; both axes are centred on it.
    localparam logic [SAMPLE_BITS-1:0] CENTRE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Squared magnitude of a centred sample pair.
    localparam int MAG2_BITS   = 2*SAMPLE_BITS;
    // Squared (radius + 1).
    localparam int LIM_BITS    = RADIUS_BITS + 1;
    localparam int LIM_SQ_BITS = 2*LIM_BITS;
    localparam int CMP_BITS    = (MAG2_BITS > LIM_SQ_BITS) ? MAG2_BITS : LIM_SQ_BITS;

    localparam int RADIUS_RST_VAL = 512;
    localparam logic [LIM_SQ_BITS-1:0] LIM_SQ_RST =
        LIM_SQ_BITS'((RADIUS_RST_VAL + 1) * (RADIUS_RST_VAL + 1));

    // Direction codes, clockwise from up.
    typedef enum logic [SECTOR_BITS-1:0] {
        SECTOR_UP         = 4'd1,
        SECTOR_UP_RIGHT   = 4'd2,
        SECTOR_RIGHT      = 4'd3,
        SECTOR_DOWN_RIGHT = 4'd4,
        SECTOR_DOWN       = 4'd5,
        SECTOR_DOWN_LEFT  = 4'd6,
        SECTOR_LEFT       = 4'd7,
        SECTOR_UP_LEFT    = 4'd8
    } t_sector;

    // Classification of one sample pair.
    typedef struct packed {
        logic    outside;
        t_sector sector;
    } t_class;

endpackage

/* rtl/core/jos_classify.sv */
// Dead-zone test and octant decode for one centred sample pair.
module jos_classify import jos_pkg::*; (
    input  logic [SAMPLE_BITS-1:0] i_x_sample,
    input  logic [SAMPLE_BITS-1:0] i_y_sample,
    input  logic [LIM_SQ_BITS-1:0] i_lim_sq,
    output t_class                 o_class
);

    logic                      x_pos;
    logic                      y_pos;
    logic [SAMPLE_BITS-1:0]    ax;
    logic [SAMPLE_BITS-1:0]    ay;
    logic [SAMPLE_BITS-1:0]    adiff;
    logic [SAMPLE_BITS:0]      asum;
    logic [2*SAMPLE_BITS-1:0]  x_sq;
    logic [2*SAMPLE_BITS-1:0]  y_sq;
    logic [MAG2_BITS-1:0]      mag2;
    logic [2*SAMPLE_BITS-1:0]  diff_sq;
    logic [2*SAMPLE_BITS+1:0]  sum_sq;
    logic                      near_h;
    logic                      near_v;

    // y axis is inverted: a low raw sample means up
    assign x_pos = (i_x_sample > CENTRE);
    assign y_pos = (i_y_sample < CENTRE);
    assign ax    = x_pos ? (i_x_sample - CENTRE) : (CENTRE - i_x_sample);
    assign ay    = y_pos ? (CENTRE - i_y_sample) : (i_y_sample - CENTRE);

    assign adiff = (ay >= ax) ? (ay - ax) : (ax - ay);
    assign asum  = {1'b0, ay} + {1'b0, ax};

    assign x_sq    = (2*SAMPLE_BITS)'(ax) * (2*SAMPLE_BITS)'(ax);
    assign y_sq    = (2*SAMPLE_BITS)'(ay) * (2*SAMPLE_BITS)'(ay);
    assign mag2    = MAG2_BITS'(x_sq) + MAG2_BITS'(y_sq);
    assign diff_sq = (2*SAMPLE_BITS)'(adiff) * (2*SAMPLE_BITS)'(adiff);
    assign sum_sq  = (2*SAMPLE_BITS+2)'(asum) * (2*SAMPLE_BITS+2)'(asum);

    // within 22.5 deg of the x axis / of the y axis
    assign near_h = (sum_sq < {1'b0, x_sq, 1'b0});
    assign near_v = ({1'b0, diff_sq} > {x_sq, 1'b0});

    always_comb begin
        o_class.outside = (CMP_BITS'(mag2) >= CMP_BITS'(i_lim_sq));
        if (near_h) begin
            o_class.sector = x_pos ? SECTOR_RIGHT : SECTOR_LEFT;
        end else if (near_v) begin
            o_class.sector = y_pos ? SECTOR_UP : SECTOR_DOWN;
        end else if (x_pos) begin
            o_class.sector = y_pos ? SECTOR_UP_RIGHT : SECTOR_DOWN_RIGHT;
        end else begin
            o_class.sector = y_pos ? SECTOR_UP_LEFT : SECTOR_DOWN_LEFT;
        end
    end

endmodule

/* rtl/core/joystick_octant_select.sv */
// Top level of the joystick eight-way direction selector with dead zone.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  in       | sink      | i_in_valid / o_in_stall   | i_x_sample, i_y_sample
//  out      | source    | o_out_valid / i_out_stall | o_sector
//  cfg      | sink      | i_cfg_valid / o_cfg_ready | i_cfg_data (dead-zone radius)
//
//  One sample pair per cycle sustained while no stalled result holds one back; each
//  pair passes the input register and then the result register on its way to a result.
//  The squares and compares sit in one stage between those two registers.
//  Synchronous active-low reset clears the valids, the selecting flag, the held
//  sector (to right) and the radius (to 512); config is always ready.
//  A stalled result only holds back a pair that would emit a result; others pass.
`include "assert_macros.svh"

module joystick_octant_select import jos_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_x_sample,
    input  logic [SAMPLE_BITS-1:0] i_y_sample,

    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SECTOR_BITS-1:0] o_sector,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [RADIUS_BITS-1:0] i_cfg_data
);

    // input stage
    logic                   r_s1_valid, n_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_x;
    logic [SAMPLE_BITS-1:0] r_s1_y;

    // (radius + 1)^2, squared once when the register is written
    logic [LIM_SQ_BITS-1:0] r_lim_sq, n_lim_sq;
    logic [LIM_BITS-1:0]    cfg_lim;

    // selection state
    logic                   r_selecting, n_selecting;
    t_sector                r_held, n_held;

    // result register
    logic                   r_out_valid, n_out_valid;
    t_sector                r_out_sector, n_out_sector;

    t_class                 cls;
    logic                   emit;
    logic                   out_free;
    logic                   s1_fire;
    logic                   in_xfer;

    jos_classify u_classify (
        .i_x_sample (r_s1_x),
        .i_y_sample (r_s1_y),
        .i_lim_sq   (r_lim_sq),
        .o_class    (cls)
    );

    // A pair emits when it falls back inside after a selection.
    assign emit     = r_s1_valid && !cls.outside && r_selecting;
    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_fire  = r_s1_valid && (out_free || !emit);

    assign o_in_stall  = r_s1_valid && !s1_fire;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_sector    = r_out_sector;

    assign cfg_lim = {1'b0, i_cfg_data} + LIM_BITS'(1);

    always_comb begin
        n_s1_valid   = in_xfer || (r_s1_valid && !s1_fire);
        n_lim_sq     = r_lim_sq;
        n_selecting  = r_selecting;
        n_held       = r_held;
        n_out_valid  = r_out_valid;
        n_out_sector = r_out_sector;

        if (i_cfg_valid && o_cfg_ready) begin
            n_lim_sq = LIM_SQ_BITS'(cfg_lim) * LIM_SQ_BITS'(cfg_lim);
        end

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (s1_fire) begin
            if (cls.outside) begin
                n_selecting = 1'b1;
                n_held      = cls.sector;
            end else if (r_selecting) begin
                n_selecting  = 1'b0;
                n_out_valid  = 1'b1;
                n_out_sector = r_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_lim_sq    <= LIM_SQ_RST;
            r_selecting <= 1'b0;
            r_held      <= SECTOR_RIGHT;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_lim_sq    <= n_lim_sq;
            r_selecting <= n_selecting;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_x <= i_x_sample;
            r_s1_y <= i_y_sample;
        end
        r_out_sector <= n_out_sector;
    end

    // A new result always comes from a selection that just ended.
    `JOS_ASSERT(a_emit_clears_sel, $rose(r_out_valid) |-> ($past(r_selecting) && !r_selecting),
        "result without a finished selection")

    `JOS_ASSERT_IMPL(a_stall_cause, o_in_stall, !out_free && emit, "stall without blocked result")

    `JOS_ASSERT_IMPL(a_sector_range, r_out_valid,
        (r_out_sector >= SECTOR_UP) && (r_out_sector <= SECTOR_UP_LEFT),
        "result sector out of range")

    `JOS_ASSERT(a_outside_sets_sel, (s1_fire && cls.outside) |=> r_selecting,
        "outside pair did not set selecting")

endmodule
